@@ rtl/core/pixel_pair_correlation_accumulator_macros.svh @@
// Assertion macros for the pixel pair correlation accumulator.
// Included by the RTL files that carry assertions; depends on nothing else.
`ifndef PIXEL_PAIR_CORRELATION_ACCUMULATOR_MACROS_SVH
`define PIXEL_PAIR_CORRELATION_ACCUMULATOR_MACROS_SVH

`ifndef SYNTH

// Antecedent implies consequent in the same cycle.
`define PPCA_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the following cycle.
`define PPCA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define PPCA_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define PPCA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

@@ rtl/core/ppca_pkg.sv @@
// Shared types, widths and constants of the pixel pair correlation accumulator.
// Has no dependencies; every other file but the assertion macro header imports it.
package ppca_pkg;

  // Field widths of the input and result words.
  localparam int PixelW     = 12;
  localparam int IntensityW = 16;
  localparam int ProductW   = 2 * IntensityW;
  localparam int SumW       = 32;
  localparam int SumProdW   = 48;
  localparam int CountW     = 17;
  localparam int MeanW      = 24;
  localparam int MeanProdW  = 40;
  localparam int FracW      = 8;
  localparam int CountMax   = (1 << CountW) - 1;

  // Default parameter values.
  localparam int PixelsDefault   = 4096;
  localparam int MaxPairsDefault = 65536;

  // Divider: three lanes share one divisor, one quotient bit per cycle.
  localparam int DivLanes   = 3;
  localparam int DivW       = SumProdW + FracW;
  localparam int DivStepW   = $clog2(DivW);
  localparam int LaneFirst  = 0;
  localparam int LaneLater  = 1;
  localparam int LaneProd   = 2;

  // Configuration port.
  localparam int PaddrW       = 3;
  localparam int PdataW       = 32;
  localparam int RegIdxW      = PaddrW - 2;
  localparam logic [RegIdxW-1:0] RegMeanFloor = RegIdxW'(0);
  localparam logic [MeanW-1:0]   FloorReset   = MeanW'(256);

  typedef enum logic {
    KindAccumulate = 1'b0,
    KindReadout    = 1'b1
  } ppca_kind_e;

  typedef enum logic [2:0] {
    StClear,
    StIdle,
    StModify,
    StDivide,
    StResult
  } ppca_state_e;

  // One entry of the per-pixel store.
  typedef struct packed {
    logic [SumW-1:0]     sum_first;
    logic [SumW-1:0]     sum_later;
    logic [SumProdW-1:0] sum_product;
    logic [CountW-1:0]   pair_count;
  } ppca_entry_t;

endpackage

@@ rtl/core/ppca_in_if.sv @@
// Input channel carrying one accumulate or readout word.
// Depends on ppca_pkg for field widths.
interface ppca_in_if
  import ppca_pkg::*;
  ();
  logic                  valid;
  logic                  ready;
  logic                  kind;
  logic [PixelW-1:0]     pixel;
  logic [IntensityW-1:0] first_intensity;
  logic [IntensityW-1:0] later_intensity;

  modport source (output valid, kind, pixel, first_intensity, later_intensity, input ready);
  modport sink   (input valid, kind, pixel, first_intensity, later_intensity, output ready);
endinterface

@@ rtl/core/ppca_out_if.sv @@
// Result channel carrying one readout word.
// Depends on ppca_pkg for field widths.
interface ppca_out_if
  import ppca_pkg::*;
  ();
  logic                 valid;
  logic                 ready;
  logic [PixelW-1:0]    pixel_out;
  logic [MeanW-1:0]     mean_first;
  logic [MeanW-1:0]     mean_later;
  logic [MeanProdW-1:0] mean_product;
  logic [CountW-1:0]    pair_total;

  modport source (output valid, pixel_out, mean_first, mean_later, mean_product, pair_total,
                  input ready);
  modport sink   (input valid, pixel_out, mean_first, mean_later, mean_product, pair_total,
                  output ready);
endinterface

@@ rtl/core/pixel_pair_correlation_accumulator.sv @@
// Per-pixel correlation store: one synchronous memory, read-modify-write, with a divider.
// Accumulate: the word is accepted with the memory read, then modified and written back.
// Readout: the entry is read and cleared, and the divider's bit loop fills the result register,
// before the next word is taken; an empty or out-of-range pixel skips the divider.
// Reset: a clearing pass over every pixel precedes the first word; the floor resets to 1.0.
// Depends on ppca_pkg, the channel interfaces, ppca_cfg_regs and ppca_divider.
`include "pixel_pair_correlation_accumulator_macros.svh"

module pixel_pair_correlation_accumulator
  import ppca_pkg::*;
#(
  parameter int PIXELS    = PixelsDefault,
  parameter int MAX_PAIRS = MaxPairsDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  ppca_in_if.sink           in_i,
  ppca_out_if.source        out_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [PdataW-1:0] pwdata,
  output logic [PdataW-1:0] prdata,
  output logic              pready
);

  localparam int AddrW = (PIXELS > 1) ? $clog2(PIXELS) : 1;
  localparam logic [AddrW-1:0]  LastAddr  = AddrW'(PIXELS - 1);
  localparam logic [CountW-1:0] PairLimit =
    CountW'((MAX_PAIRS < CountMax) ? MAX_PAIRS : CountMax);

  ppca_state_e state_q, state_d;

  // Memory and its ports.
  ppca_entry_t store_mem [PIXELS];
  ppca_entry_t rd_data_q;
  ppca_entry_t mem_wdata;
  ppca_entry_t acc_entry;
  logic [AddrW-1:0] mem_raddr, mem_waddr;
  logic             mem_we;
  logic [AddrW-1:0] clr_addr_q;

  // Word held while it is worked on.
  ppca_kind_e            kind_q;
  logic [PixelW-1:0]     pixel_q;
  logic                  in_range_q;
  logic [IntensityW-1:0] first_q, later_q;
  logic [ProductW-1:0]   product_q;
  logic [CountW-1:0]     res_count_q;

  // Control outputs of the state machine.
  logic in_ready, in_accept, acc_ok, div_start, div_busy, out_load, out_valid_q;

  logic [MeanW-1:0] mean_floor;
  logic [DivLanes-1:0][DivW-1:0] div_dividend, div_quotient;

  // Result register.
  logic [PixelW-1:0]    out_pixel_q;
  logic [MeanW-1:0]     out_mean_first_q, out_mean_later_q;
  logic [MeanProdW-1:0] out_mean_product_q;
  logic [CountW-1:0]    out_pair_total_q;
  logic [MeanProdW-1:0] q_first, q_later, floor_ext;

  ppca_cfg_regs u_cfg_regs (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .mean_floor_o (mean_floor)
  );

  ppca_divider u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (rd_data_q.pair_count),
    .busy_o     (div_busy),
    .quotient_o (div_quotient)
  );

  assign in_accept = in_i.valid && in_ready;
  assign in_i.ready = in_ready;

  // Synchronous memory: one write and one registered read per cycle.
  assign mem_raddr = AddrW'(in_i.pixel);
  assign mem_waddr = (state_q == StClear) ? clr_addr_q : AddrW'(pixel_q);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      store_mem[mem_waddr] <= mem_wdata;
    end
    rd_data_q <= store_mem[mem_raddr];
  end

  // Saturating update of the entry for an accumulate word.
  always_comb begin
    logic [SumW:0]     sf, sl;
    logic [SumProdW:0] sp;
    sf = {1'b0, rd_data_q.sum_first} + (SumW + 1)'(first_q);
    sl = {1'b0, rd_data_q.sum_later} + (SumW + 1)'(later_q);
    sp = {1'b0, rd_data_q.sum_product} + (SumProdW + 1)'(product_q);
    acc_entry.sum_first   = sf[SumW] ? '1 : sf[SumW-1:0];
    acc_entry.sum_later   = sl[SumW] ? '1 : sl[SumW-1:0];
    acc_entry.sum_product = sp[SumProdW] ? '1 : sp[SumProdW-1:0];
    acc_entry.pair_count  = rd_data_q.pair_count + 1'b1;
  end

  assign acc_ok = in_range_q && (rd_data_q.pair_count < PairLimit);

  // Dividends carry the 8 fraction bits below each sum.
  assign div_dividend[LaneFirst] = DivW'({rd_data_q.sum_first, {FracW{1'b0}}});
  assign div_dividend[LaneLater] = DivW'({rd_data_q.sum_later, {FracW{1'b0}}});
  assign div_dividend[LaneProd]  = {rd_data_q.sum_product, {FracW{1'b0}}};

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      StClear: begin
        if (clr_addr_q == LastAddr) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (in_i.valid) begin
          state_d = StModify;
        end
      end
      StModify: begin
        if (kind_q == KindAccumulate) begin
          state_d = StIdle;
        end else if (div_start) begin
          state_d = StDivide;
        end else begin
          state_d = StResult;
        end
      end
      StDivide: begin
        if (!div_busy) begin
          state_d = StResult;
        end
      end
      StResult: begin
        if (out_load) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // State machine outputs.
  always_comb begin
    in_ready  = 1'b0;
    mem_we    = 1'b0;
    mem_wdata = '0;
    div_start = 1'b0;
    out_load  = 1'b0;
    case (state_q)
      StClear: begin
        mem_we = 1'b1;
      end
      StIdle: begin
        in_ready = 1'b1;
      end
      StModify: begin
        if (kind_q == KindAccumulate) begin
          mem_we    = acc_ok;
          mem_wdata = acc_entry;
        end else begin
          mem_we    = in_range_q;
          div_start = in_range_q && (rd_data_q.pair_count != '0);
        end
      end
      StResult: begin
        out_load = !out_valid_q || out_o.ready;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      clr_addr_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_load || (out_valid_q && !out_o.ready);
      if (state_q == StClear) begin
        clr_addr_q <= clr_addr_q + 1'b1;
      end
    end
  end

  // Word registers and the product, registered ahead of the add.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      kind_q     <= ppca_kind_e'(in_i.kind);
      pixel_q    <= in_i.pixel;
      in_range_q <= (32'(in_i.pixel) < PIXELS);
      first_q    <= in_i.first_intensity;
      later_q    <= in_i.later_intensity;
      product_q  <= ProductW'(in_i.first_intensity) * ProductW'(in_i.later_intensity);
    end
    if (state_q == StModify) begin
      res_count_q <= in_range_q ? rd_data_q.pair_count : '0;
    end
  end

  // Clamp the intensity means to the floor; the product mean is not clamped.
  assign q_first   = div_quotient[LaneFirst][MeanProdW-1:0];
  assign q_later   = div_quotient[LaneLater][MeanProdW-1:0];
  assign floor_ext = MeanProdW'(mean_floor);

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_pixel_q <= pixel_q;
      if (res_count_q == '0) begin
        out_mean_first_q   <= '0;
        out_mean_later_q   <= '0;
        out_mean_product_q <= '0;
        out_pair_total_q   <= '0;
      end else begin
        out_mean_first_q   <= (q_first < floor_ext) ? mean_floor : q_first[MeanW-1:0];
        out_mean_later_q   <= (q_later < floor_ext) ? mean_floor : q_later[MeanW-1:0];
        out_mean_product_q <= div_quotient[LaneProd][MeanProdW-1:0];
        out_pair_total_q   <= res_count_q;
      end
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.pixel_out    = out_pixel_q;
  assign out_o.mean_first   = out_mean_first_q;
  assign out_o.mean_later   = out_mean_later_q;
  assign out_o.mean_product = out_mean_product_q;
  assign out_o.pair_total   = out_pair_total_q;

  // An accumulate write never takes the count past the limit.
  `PPCA_ASSERT_IMPL(a_count_limit, clk_i, rst_ni, mem_we && (state_q == StModify) && (kind_q == KindAccumulate), (mem_wdata.pair_count <= PairLimit) && (mem_wdata.pair_count != '0), "pair count written beyond limit")
  // The divider is never started with a zero divisor.
  `PPCA_ASSERT_IMPL(a_div_nonzero, clk_i, rst_ni, div_start, rd_data_q.pair_count != '0, "divider started with zero count")
  // A new word is never taken while a division is running.
  `PPCA_ASSERT_IMPL(a_ready_idle_div, clk_i, rst_ni, in_ready, !div_busy, "input ready during division")
  // A result appears only after the result state.
  `PPCA_ASSERT_NEXT(a_result_src, clk_i, rst_ni, !out_valid_q && !out_load, !out_valid_q, "result appeared without load")

endmodule

@@ rtl/core/ppca_cfg_regs.sv @@
// APB-style register file holding the mean floor.
// Depends on ppca_pkg for the register map and reset value.
module ppca_cfg_regs
  import ppca_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [PdataW-1:0] pwdata,
  output logic [PdataW-1:0] prdata,
  output logic              pready,
  output logic [MeanW-1:0]  mean_floor_o
);

  logic [MeanW-1:0]   mean_floor_q;
  logic [RegIdxW-1:0] reg_idx;
  logic               wr_en;

  // Register index is the word address; byte offset bits are ignored.
  assign reg_idx = paddr[PaddrW-1:2];
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && (reg_idx == RegMeanFloor);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mean_floor_q <= FloorReset;
    end else if (wr_en) begin
      mean_floor_q <= pwdata[MeanW-1:0];
    end
  end

  // Read data returns the register, zero elsewhere.
  always_comb begin
    prdata = '0;
    if (reg_idx == RegMeanFloor) begin
      prdata = PdataW'(mean_floor_q);
    end
  end

  assign mean_floor_o = mean_floor_q;

endmodule

@@ rtl/core/ppca_divider.sv @@
// Restoring divider with three lanes sharing one divisor, one quotient bit per cycle.
// Depends on ppca_pkg for lane count and widths.
module ppca_divider
  import ppca_pkg::*;
(
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [DivLanes-1:0][DivW-1:0]    dividend_i,
  input  logic [CountW-1:0]                divisor_i,
  output logic                             busy_o,
  output logic [DivLanes-1:0][DivW-1:0]    quotient_o
);

  logic [DivLanes-1:0][DivW-1:0]   dq_q, dq_d;
  logic [DivLanes-1:0][CountW-1:0] rem_q, rem_d;
  logic [CountW-1:0]               divisor_q;
  logic [DivStepW-1:0]             step_q;
  logic                            busy_q;

  // One restoring step per lane: shift in the next dividend bit, subtract if it fits.
  always_comb begin
    logic [CountW:0] rem_sh;
    logic [CountW:0] diff;
    logic            fits;
    for (int l = 0; l < DivLanes; l++) begin
      rem_sh   = {rem_q[l], dq_q[l][DivW-1]};
      diff     = rem_sh - {1'b0, divisor_q};
      fits     = rem_sh >= {1'b0, divisor_q};
      rem_d[l] = fits ? diff[CountW-1:0] : rem_sh[CountW-1:0];
      dq_d[l]  = {dq_q[l][DivW-2:0], fits};
    end
  end

  // Step counter and busy flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      step_q <= DivStepW'(DivW - 1);
    end else if (busy_q) begin
      if (step_q == '0) begin
        busy_q <= 1'b0;
      end else begin
        step_q <= step_q - 1'b1;
      end
    end
  end

  // Dividend, quotient and remainder registers.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dq_q      <= dividend_i;
      rem_q     <= '0;
      divisor_q <= divisor_i;
    end else if (busy_q) begin
      dq_q  <= dq_d;
      rem_q <= rem_d;
    end
  end

  assign busy_o     = busy_q;
  assign quotient_o = dq_q;

endmodule

@@ tb/ppca_checker.sv @@
// Checker for the pixel pair correlation accumulator: watches both channels and the APB port.
// Keeps its own per-pixel sums, predicts every readout word and compares it field by field.
// Depends on ppca_pkg and the ppca_in_if / ppca_out_if channel interfaces.
module ppca_checker
  import ppca_pkg::*;
#(
  parameter int PIXELS    = PixelsDefault,
  parameter int MAX_PAIRS = MaxPairsDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  ppca_in_if                in_mon,
  ppca_out_if               out_mon,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [PdataW-1:0] pwdata,
  input  logic              pready,
  output int                mismatch_count,
  output int                means_waiting,
  output int                means_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint unsigned PairCap = (MAX_PAIRS < CountMax) ? MAX_PAIRS : CountMax;
  localparam logic [63:0] Sum32Top = 64'h0000_0000_FFFF_FFFF;
  localparam logic [63:0] Sum48Top = 64'h0000_FFFF_FFFF_FFFF;
  localparam int ReportLimit = 10;

  // One readout word as the block should send it.
  typedef struct packed {
    logic [PixelW-1:0]    pixel;
    logic [MeanW-1:0]     mean_first;
    logic [MeanW-1:0]     mean_later;
    logic [MeanProdW-1:0] mean_product;
    logic [CountW-1:0]    pair_total;
  } pixel_means_t;

  // Shadow copy of the per-pixel store and the floor register.
  logic [SumW-1:0]     first_sums   [PIXELS];
  logic [SumW-1:0]     later_sums   [PIXELS];
  logic [SumProdW-1:0] product_sums [PIXELS];
  logic [CountW-1:0]   pair_counts  [PIXELS];
  logic [MeanW-1:0]    mean_floor_q;
  pixel_means_t        expected_means_q [$];

  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b,
                                          input logic [63:0] top);
    if (a >= top || b > top - a) return top;
    return a + b;
  endfunction

  // Folds one accepted word into the shadow sums; a readout queues its means and clears.
  task automatic correlate_word(input logic kind, input logic [PixelW-1:0] pix,
                                input logic [IntensityW-1:0] a, input logic [IntensityW-1:0] b);
    logic [63:0]  n;
    logic [63:0]  mf;
    logic [63:0]  ml;
    logic [63:0]  mp;
    logic [63:0]  prod;
    pixel_means_t m;
    m = '0;
    m.pixel = pix;
    if (kind == KindAccumulate) begin
      if (pix < PIXELS && pair_counts[pix] < PairCap) begin
        prod = 64'(a) * 64'(b);
        first_sums[pix]   = SumW'(sat_add(64'(first_sums[pix]), 64'(a), Sum32Top));
        later_sums[pix]   = SumW'(sat_add(64'(later_sums[pix]), 64'(b), Sum32Top));
        product_sums[pix] = SumProdW'(sat_add(64'(product_sums[pix]), prod, Sum48Top));
        pair_counts[pix]  = pair_counts[pix] + 1'b1;
      end
    end else begin
      if (pix < PIXELS) begin
        // An empty pixel reads as zeros with no floor applied.
        if (pair_counts[pix] != 0) begin
          n  = 64'(pair_counts[pix]);
          mf = (64'(first_sums[pix]) << FracW) / n;
          ml = (64'(later_sums[pix]) << FracW) / n;
          mp = (64'(product_sums[pix]) << FracW) / n;
          if (mf < 64'(mean_floor_q)) mf = 64'(mean_floor_q);
          if (ml < 64'(mean_floor_q)) ml = 64'(mean_floor_q);
          m.mean_first   = MeanW'(mf);
          m.mean_later   = MeanW'(ml);
          m.mean_product = MeanProdW'(mp);
          m.pair_total   = CountW'(n);
        end
        first_sums[pix]   = '0;
        later_sums[pix]   = '0;
        product_sums[pix] = '0;
        pair_counts[pix]  = '0;
      end
      expected_means_q.push_back(m);
    end
  endtask

  // All handshakes are sampled at the rising edge, values as they stood before it.
  always @(posedge clk_i) begin
    pixel_means_t got;
    pixel_means_t want;
    if (!rst_ni) begin
      for (int p = 0; p < PIXELS; p++) begin
        first_sums[p]   = '0;
        later_sums[p]   = '0;
        product_sums[p] = '0;
        pair_counts[p]  = '0;
      end
      mean_floor_q = FloorReset;
      expected_means_q.delete();
      mismatch_count = 0;
      means_checked  = 0;
      means_waiting  = 0;
    end else begin
      // Register write on the APB access cycle.
      if (psel && penable && pwrite && pready && paddr[PaddrW-1:2] == RegMeanFloor) begin
        mean_floor_q = pwdata[MeanW-1:0];
      end

      // Result word against the oldest expectation.
      if (out_mon.valid && out_mon.ready) begin
        got.pixel        = out_mon.pixel_out;
        got.mean_first   = out_mon.mean_first;
        got.mean_later   = out_mon.mean_later;
        got.mean_product = out_mon.mean_product;
        got.pair_total   = out_mon.pair_total;
        if (expected_means_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= ReportLimit)
            $display("unexpected result word: pixel %0d mf %h ml %h mp %h n %0d",
                     got.pixel, got.mean_first, got.mean_later, got.mean_product,
                     got.pair_total);
        end else begin
          want = expected_means_q.pop_front();
          means_checked++;
          if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= ReportLimit)
              $display("readout mismatch: expected pixel %0d mf %h ml %h mp %h n %0d\n%s%0d %s%h %s%h %s%h %s%0d",
                       want.pixel, want.mean_first, want.mean_later, want.mean_product,
                       want.pair_total, "                 got pixel ", got.pixel,
                       "mf", got.mean_first, "ml", got.mean_later, "mp", got.mean_product,
                       "n", got.pair_total);
          end
        end
      end

      // Input word into the shadow store.
      if (in_mon.valid && in_mon.ready) begin
        correlate_word(in_mon.kind, in_mon.pixel, in_mon.first_intensity,
                       in_mon.later_intensity);
      end
      means_waiting = expected_means_q.size();
    end
  end

endmodule

@@ tb/tb_top.sv @@
// Top of the pixel pair correlation accumulator testbench: clock, reset, stimulus and verdict.
// Depends on ppca_pkg, the channel interfaces, the block itself and ppca_checker.
module tb_top;
  import ppca_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit   = 1_000_000;
  localparam int SettleCycles = 80;
  localparam int DrainCycles  = 100;
  localparam int FillPairs    = 16;
  localparam int PhaseItems   = 450;
  localparam int PoolSize     = 6;

  logic              clk_i;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [PaddrW-1:0] paddr;
  logic [PdataW-1:0] pwdata;
  logic [PdataW-1:0] prdata;
  logic              pready;

  int send_idle_pct;
  int recv_stall_pct;
  int words_sent;
  int floor_writes;
  int cycle_count = 0;
  int mismatch_count;
  int means_waiting;
  int means_checked;

  logic [PixelW-1:0] pixel_pool [PoolSize];

  ppca_in_if  in_if ();
  ppca_out_if out_if ();

  pixel_pair_correlation_accumulator u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  ppca_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_mon         (in_if),
    .out_mon        (out_if),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .pready         (pready),
    .mismatch_count (mismatch_count),
    .means_waiting  (means_waiting),
    .means_checked  (means_checked)
  );

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Result side: ready drops at random according to the current stall rate.
  always @(posedge clk_i) begin
    out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("timeout after %0d cycles, %0d readouts still waiting", cycle_count,
               means_waiting);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Offers one word, with random idle cycles first, and returns once it is taken.
  task automatic send_word(input ppca_kind_e kind, input logic [PixelW-1:0] pix,
                           input logic [IntensityW-1:0] a, input logic [IntensityW-1:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid           <= 1'b1;
    in_if.kind            <= kind;
    in_if.pixel           <= pix;
    in_if.first_intensity <= a;
    in_if.later_intensity <= b;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    words_sent++;
  endtask

  // Holds the input off until every queued readout has come back.
  task automatic drain_results();
    in_if.valid <= 1'b0;
    do @(negedge clk_i); while (means_waiting != 0);
    @(posedge clk_i);
  endtask

  // Quiet point for a register write: results drained, accumulates written back.
  task automatic write_floor(input logic [PdataW-1:0] value);
    drain_results();
    repeat (SettleCycles) @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {RegMeanFloor, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    floor_writes++;
  endtask

  function automatic logic [IntensityW-1:0] pick_intensity();
    int r;
    r = $urandom_range(9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (r == 2) return IntensityW'($urandom_range(255));
    return IntensityW'($urandom_range(65535));
  endfunction

  // Mostly a few busy pixels, so sums grow deep; sometimes any pixel at all.
  function automatic logic [PixelW-1:0] pick_pixel();
    if ($urandom_range(9) < 8) return pixel_pool[$urandom_range(PoolSize - 1)];
    return PixelW'($urandom_range(4095));
  endfunction

  task automatic random_phase(input int idle_pct, input int stall_pct,
                              input logic [PdataW-1:0] floor_value);
    ppca_kind_e kind;
    write_floor(floor_value);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < PoolSize; i++) pixel_pool[i] = PixelW'($urandom_range(4095));
    if ($urandom_range(1)) pixel_pool[0] = '1;
    else pixel_pool[0] = '0;
    for (int i = 0; i < PhaseItems; i++) begin
      // Now and then let the block run dry mid-phase.
      if ($urandom_range(149) == 0) drain_results();
      kind = ($urandom_range(99) < 75) ? KindAccumulate : KindReadout;
      send_word(kind, pick_pixel(), pick_intensity(), pick_intensity());
    end
  endtask

  initial begin
    rst_ni                = 1'b0;
    psel                  = 1'b0;
    penable               = 1'b0;
    pwrite                = 1'b0;
    paddr                 = '0;
    pwdata                = '0;
    in_if.valid           = 1'b0;
    in_if.kind            = KindAccumulate;
    in_if.pixel           = '0;
    in_if.first_intensity = '0;
    in_if.later_intensity = '0;
    out_if.ready          = 1'b0;
    send_idle_pct         = 0;
    recv_stall_pct        = 0;
    words_sent            = 0;
    floor_writes          = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed words at the reset floor: empty pixel, zero and full-scale pairs,
    // back-to-back updates of one pixel and readout after clear.
    send_word(KindReadout, 12'd0, 16'hFFFF, 16'hFFFF);
    send_word(KindAccumulate, 12'd0, 16'h0000, 16'h0000);
    send_word(KindReadout, 12'd0, 16'h0000, 16'h0000);
    repeat (3) send_word(KindAccumulate, 12'hFFF, 16'hFFFF, 16'hFFFF);
    send_word(KindReadout, 12'hFFF, 16'h0000, 16'h0000);
    send_word(KindAccumulate, 12'd5, 16'd1, 16'hFFFF);
    send_word(KindAccumulate, 12'd5, 16'd2, 16'd0);
    send_word(KindReadout, 12'd5, 16'h0000, 16'h0000);
    send_word(KindAccumulate, 12'd7, 16'd100, 16'd200);
    send_word(KindAccumulate, 12'd7, 16'd300, 16'd400);
    send_word(KindReadout, 12'd7, 16'h0000, 16'h0000);
    send_word(KindReadout, 12'd7, 16'h0000, 16'h0000);
    send_word(KindAccumulate, 12'hAAA, 16'h5555, 16'hAAAA);
    send_word(KindAccumulate, 12'h555, 16'hAAAA, 16'h5555);
    send_word(KindReadout, 12'hAAA, 16'h0000, 16'h0000);
    send_word(KindReadout, 12'h555, 16'h0000, 16'h0000);

    // Floor at zero, then at its maximum with junk in the unused data bits.
    write_floor(32'h0000_0000);
    send_word(KindAccumulate, 12'd9, 16'd0, 16'd3);
    send_word(KindReadout, 12'd9, 16'h0000, 16'h0000);
    write_floor(32'hFFFF_FFFF);
    send_word(KindAccumulate, 12'd9, 16'hFFFF, 16'hFFFF);
    send_word(KindReadout, 12'd9, 16'h0000, 16'h0000);
    send_word(KindReadout, 12'd9, 16'h0000, 16'h0000);

    // A run of pairs on one pixel, then its readout.
    write_floor(32'(FloorReset));
    for (int i = 0; i < FillPairs; i++) begin
      send_word(KindAccumulate, 12'd3, pick_intensity(), pick_intensity());
    end
    send_word(KindReadout, 12'd3, 16'h0000, 16'h0000);

    // Random traffic under four pacing settings and assorted floors.
    random_phase(0, 0, 32'(FloorReset));
    random_phase(75, 0, 32'h0000_0000);
    random_phase(0, 75, 32'($urandom_range(24'hFF_FFFF)));
    random_phase(21, 21, 32'($urandom_range(24'h00_FFFF)));

    drain_results();
    repeat (DrainCycles) @(posedge clk_i);
    @(negedge clk_i);
    $display("Covered %0d input words and %0d checked readouts: empty and deep pixels,",
             words_sent, means_checked);
    $display("%0d floor settings, four pacing phases; %0d mismatches.", floor_writes,
             mismatch_count);
    if (mismatch_count == 0 && means_waiting == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
